[hdl/h2r_pkg.sv]
// Shared constants, types and widths for the HSL to RGB converter.
`default_nettype none

package h2r_pkg;

    // Fixed-point format: unsigned fractions with FRACTION_BITS fractional bits.
    localparam int FRACTION_BITS = 16;
    // A value in 0 .. ONE.
    localparam int FRAC_W = FRACTION_BITS + 1;
    // A value in 0 .. 2*ONE.
    localparam int WIDE_W = FRACTION_BITS + 2;
    // A channel value before byte conversion, with headroom.
    localparam int SUM_W = FRACTION_BITS + 3;
    // Product of a wide difference and a slope.
    localparam int PROD_W = WIDE_W + FRAC_W;

    localparam logic [FRAC_W-1:0] FX_ONE = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [FRAC_W-1:0] FX_THIRD = FRAC_W'((64'd1 << FRACTION_BITS) / 3);
    localparam logic [FRAC_W-1:0] FX_TWO_THIRDS = FRAC_W'((64'd2 << FRACTION_BITS) / 3);

    // Reciprocals for the byte and degree scaling, with 8 and 9 guard bits.
    localparam logic [FRAC_W-1:0] RECIP_255 =
        FRAC_W'((64'd1 << (FRACTION_BITS + 8)) / 255);
    localparam logic [FRAC_W-1:0] RECIP_360 =
        FRAC_W'((64'd1 << (FRACTION_BITS + 9)) / 360);

    localparam logic [8:0] HUE_RANGE = 9'd360;
    localparam logic [7:0] BYTE_MAX = 8'd255;

    // Channel slots in a job.
    localparam int CH_RED = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE = 2;
    localparam int NUM_CH = 3;

    // Queue between front and back end; the depth also bounds items in flight.
    localparam int QUEUE_DEPTH = 8;
    localparam int QADDR_W = $clog2(QUEUE_DEPTH);
    localparam int QCOUNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef logic [FRAC_W-1:0] frac_t;
    typedef logic [WIDE_W-1:0] wide_t;

    // One classified pixel: each channel is v1 + diff * slope / ONE.
    typedef struct packed {
        logic                     gray;
        logic [7:0]               lightness;
        wide_t                    v1;
        wide_t                    diff;
        logic [NUM_CH-1:0][FRAC_W-1:0] slope;
    } h2r_job_t;

endpackage

`default_nettype wire

[hdl/h2r_front.sv]
// Front end: scales the inputs to fixed point, forms v1 and v2 and picks each channel's slope.
`default_nettype none

module h2r_front
    import h2r_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    input  wire logic [8:0]  in_hue_degrees,
    input  wire logic [7:0]  in_saturation,
    input  wire logic [7:0]  in_lightness,
    output logic             job_valid,
    output h2r_job_t         job
);

    // Slope for one shifted hue: rising edge, flat top, falling edge or flat base.
    function automatic frac_t slope_of(input frac_t t);
        logic [FRAC_W+2:0] six_t;
        logic [FRAC_W+1:0] three_t;
        frac_t             gap;
        logic [FRAC_W+1:0] six_gap;
        frac_t             slope;
        six_t   = {2'b00, t, 1'b0} + {1'b0, t, 2'b00};
        three_t = {1'b0, t, 1'b0} + {2'b00, t};
        gap     = FX_TWO_THIRDS - t;
        six_gap = {1'b0, gap, 1'b0} + {gap, 2'b00};
        if (six_t < {3'b000, FX_ONE}) begin
            slope = six_t[FRAC_W-1:0];
        end else if ({t, 1'b0} < {1'b0, FX_ONE}) begin
            slope = FX_ONE;
        end else if (three_t < {1'b0, FX_ONE, 1'b0}) begin
            slope = six_gap[FRAC_W-1:0];
        end else begin
            slope = '0;
        end
        return slope;
    endfunction

    // Stage 1: hue wrap and reciprocal multiplies.
    logic [8:0]            hue_wrap;
    logic [FRAC_W+7:0]     sat_prod;
    logic [FRAC_W+7:0]     lit_prod;
    logic [FRAC_W+8:0]     hue_prod;
    logic                  s1_valid_reg;
    logic                  s1_gray_reg;
    logic [7:0]            s1_sat_reg;
    logic [7:0]            s1_lit_reg;
    logic [8:0]            s1_hue_reg;
    frac_t                 s1_sq_reg;
    frac_t                 s1_lq_reg;
    frac_t                 s1_hq_reg;

    assign hue_wrap = (in_hue_degrees >= HUE_RANGE) ? in_hue_degrees - HUE_RANGE
                                                    : in_hue_degrees;
    assign sat_prod = (FRAC_W+8)'(in_saturation) * (FRAC_W+8)'(RECIP_255);
    assign lit_prod = (FRAC_W+8)'(in_lightness) * (FRAC_W+8)'(RECIP_255);
    assign hue_prod = (FRAC_W+9)'(hue_wrap) * (FRAC_W+9)'(RECIP_360);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid;
        end
        s1_gray_reg <= (in_saturation == 8'd0);
        s1_sat_reg  <= in_saturation;
        s1_lit_reg  <= in_lightness;
        s1_hue_reg  <= hue_wrap;
        s1_sq_reg   <= sat_prod[FRAC_W+7:8];
        s1_lq_reg   <= lit_prod[FRAC_W+7:8];
        s1_hq_reg   <= hue_prod[FRAC_W+8:9];
    end

    // Stage 2: remainder check lifts each quotient by one where it fell short.
    logic [FRACTION_BITS+8:0] rem_s;
    logic [FRACTION_BITS+8:0] rem_l;
    logic [FRACTION_BITS+9:0] rem_h;
    frac_t                    s_next;
    frac_t                    l_next;
    frac_t                    h_next;
    logic                     s2_valid_reg;
    logic                     s2_gray_reg;
    logic [7:0]               s2_lit_reg;
    frac_t                    s2_s_reg;
    frac_t                    s2_l_reg;
    frac_t                    s2_h_reg;

    assign rem_s = {1'b0, s1_sat_reg, {FRACTION_BITS{1'b0}}}
                 - ((FRACTION_BITS+9)'(s1_sq_reg) * (FRACTION_BITS+9)'(255));
    assign rem_l = {1'b0, s1_lit_reg, {FRACTION_BITS{1'b0}}}
                 - ((FRACTION_BITS+9)'(s1_lq_reg) * (FRACTION_BITS+9)'(255));
    assign rem_h = {1'b0, s1_hue_reg, {FRACTION_BITS{1'b0}}}
                 - ((FRACTION_BITS+10)'(s1_hq_reg) * (FRACTION_BITS+10)'(HUE_RANGE));
    assign s_next = (rem_s >= (FRACTION_BITS+9)'(BYTE_MAX)) ? s1_sq_reg + 1'b1 : s1_sq_reg;
    assign l_next = (rem_l >= (FRACTION_BITS+9)'(BYTE_MAX)) ? s1_lq_reg + 1'b1 : s1_lq_reg;
    assign h_next = (rem_h >= (FRACTION_BITS+10)'(HUE_RANGE)) ? s1_hq_reg + 1'b1
                                                             : s1_hq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg;
        end
        s2_gray_reg <= s1_gray_reg;
        s2_lit_reg  <= s1_lit_reg;
        s2_s_reg    <= s_next;
        s2_l_reg    <= l_next;
        s2_h_reg    <= h_next;
    end

    // Stage 3: product l*s and the two shifted hues.
    logic [2*FRAC_W-1:0] ls_prod;
    logic [FRAC_W:0]     tr_sum;
    frac_t               tr_next;
    frac_t               tb_next;
    logic                s3_valid_reg;
    logic                s3_gray_reg;
    logic [7:0]          s3_lit_reg;
    frac_t               s3_s_reg;
    frac_t               s3_l_reg;
    frac_t               s3_p_reg;
    logic                s3_low_reg;
    frac_t               s3_tr_reg;
    frac_t               s3_tg_reg;
    frac_t               s3_tb_reg;

    assign ls_prod = (2*FRAC_W)'(s2_l_reg) * (2*FRAC_W)'(s2_s_reg);
    assign tr_sum  = {1'b0, s2_h_reg} + {1'b0, FX_THIRD};
    assign tr_next = (tr_sum >= {1'b0, FX_ONE}) ? FRAC_W'(tr_sum - {1'b0, FX_ONE})
                                                : tr_sum[FRAC_W-1:0];
    assign tb_next = (s2_h_reg >= FX_THIRD) ? s2_h_reg - FX_THIRD
                                            : s2_h_reg + FX_ONE - FX_THIRD;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else begin
            s3_valid_reg <= s2_valid_reg;
        end
        s3_gray_reg <= s2_gray_reg;
        s3_lit_reg  <= s2_lit_reg;
        s3_s_reg    <= s2_s_reg;
        s3_l_reg    <= s2_l_reg;
        s3_p_reg    <= ls_prod[FRACTION_BITS +: FRAC_W];
        s3_low_reg  <= ({s2_l_reg, 1'b0} < {1'b0, FX_ONE});
        s3_tr_reg   <= tr_next;
        s3_tg_reg   <= s2_h_reg;
        s3_tb_reg   <= tb_next;
    end

    // Stage 4: v2 and the per-channel slopes.
    wide_t                         v2_next;
    logic                          s4_valid_reg;
    logic                          s4_gray_reg;
    logic [7:0]                    s4_lit_reg;
    frac_t                         s4_l_reg;
    wide_t                         s4_v2_reg;
    logic [NUM_CH-1:0][FRAC_W-1:0] s4_slope_reg;

    assign v2_next = s3_low_reg
        ? WIDE_W'(s3_l_reg) + WIDE_W'(s3_p_reg)
        : WIDE_W'(s3_l_reg) + WIDE_W'(s3_s_reg) - WIDE_W'(s3_p_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else begin
            s4_valid_reg <= s3_valid_reg;
        end
        s4_gray_reg            <= s3_gray_reg;
        s4_lit_reg             <= s3_lit_reg;
        s4_l_reg               <= s3_l_reg;
        s4_v2_reg              <= v2_next;
        s4_slope_reg[CH_RED]   <= slope_of(s3_tr_reg);
        s4_slope_reg[CH_GREEN] <= slope_of(s3_tg_reg);
        s4_slope_reg[CH_BLUE]  <= slope_of(s3_tb_reg);
    end

    // v1 = 2l - v2, both kept ordered; the job leaves toward the queue.
    wide_t two_l;
    wide_t v1;
    wide_t v2_ord;

    assign two_l  = {s4_l_reg, 1'b0};
    assign v1     = (s4_v2_reg > two_l) ? '0 : two_l - s4_v2_reg;
    assign v2_ord = (s4_v2_reg < v1) ? v1 : s4_v2_reg;

    assign job_valid     = s4_valid_reg;
    assign job.gray      = s4_gray_reg;
    assign job.lightness = s4_lit_reg;
    assign job.v1        = v1;
    assign job.diff      = v2_ord - v1;
    assign job.slope     = s4_slope_reg;

endmodule

`default_nettype wire

[hdl/h2r_queue.sv]
// Small first-in first-out queue of classified pixels between front and back end.
`default_nettype none

module h2r_queue
    import h2r_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     wr_valid,
    input  wire h2r_job_t wr_job,
    output logic          rd_valid,
    input  wire logic     rd_ready,
    output h2r_job_t      rd_job
);

    h2r_job_t              entry_reg [QUEUE_DEPTH];
    logic [QADDR_W-1:0]    wr_ptr_reg;
    logic [QADDR_W-1:0]    rd_ptr_reg;
    logic [QCOUNT_W-1:0]   count_reg;
    logic [QADDR_W-1:0]    wr_ptr_next;
    logic [QADDR_W-1:0]    rd_ptr_next;
    logic                  pop;

    // The input credit counter keeps writes from ever exceeding the depth.
    assign rd_valid = (count_reg != '0);
    assign rd_job   = entry_reg[rd_ptr_reg];
    assign pop      = rd_valid && rd_ready;

    assign wr_ptr_next = (wr_ptr_reg == QADDR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == QADDR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    // Pointer and fill count update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_valid) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_reg + QCOUNT_W'(wr_valid) - QCOUNT_W'(pop);
        end
    end

    // Storage write.
    always_ff @(posedge aclk) begin
        if (wr_valid) begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

`default_nettype wire

[hdl/h2r_back.sv]
// Back end: evaluates the three channels, converts them to bytes and holds the result.
`default_nettype none

module h2r_back
    import h2r_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     job_valid,
    output logic          job_ready,
    input  wire h2r_job_t job,
    output logic          m_valid,
    input  wire logic     m_ready,
    output logic [7:0]    m_red,
    output logic [7:0]    m_green,
    output logic [7:0]    m_blue
);

    // Each stage moves on when it is empty or the next one takes its transfer.
    logic b1_valid_reg;
    logic b2_valid_reg;
    logic m_valid_reg;
    logic out_ready;
    logic b2_ready;
    logic b1_ready;

    assign out_ready = !m_valid_reg || m_ready;
    assign b2_ready  = !b2_valid_reg || out_ready;
    assign b1_ready  = !b1_valid_reg || b2_ready;
    assign job_ready = b1_ready;
    assign m_valid   = m_valid_reg;

    // Stage 1: diff times slope for each channel.
    logic [NUM_CH-1:0][PROD_W-1:0] b1_prod_reg;
    wide_t                         b1_v1_reg;
    logic                          b1_gray_reg;
    logic [7:0]                    b1_lit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg <= 1'b0;
        end else if (b1_ready) begin
            b1_valid_reg <= job_valid;
        end
        if (b1_ready) begin
            for (int c = 0; c < NUM_CH; c++) begin
                b1_prod_reg[c] <= PROD_W'(job.diff) * PROD_W'(job.slope[c]);
            end
            b1_v1_reg   <= job.v1;
            b1_gray_reg <= job.gray;
            b1_lit_reg  <= job.lightness;
        end
    end

    // Stage 2: channel value v1 + product / ONE.
    logic [NUM_CH-1:0][SUM_W-1:0] b2_chan_reg;
    logic                         b2_gray_reg;
    logic [7:0]                   b2_lit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b2_valid_reg <= 1'b0;
        end else if (b2_ready) begin
            b2_valid_reg <= b1_valid_reg;
        end
        if (b2_ready) begin
            for (int c = 0; c < NUM_CH; c++) begin
                b2_chan_reg[c] <= SUM_W'(b1_v1_reg)
                                + b1_prod_reg[c][FRACTION_BITS +: SUM_W];
            end
            b2_gray_reg <= b1_gray_reg;
            b2_lit_reg  <= b1_lit_reg;
        end
    end

    // Stage 3: scale by 255, truncate and saturate into the output register; a gray pixel takes its lightness byte.
    logic [NUM_CH-1:0][SUM_W+7:0] scaled;
    logic [NUM_CH-1:0][7:0]       byte_next;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            scaled[c] = {b2_chan_reg[c], 8'd0} - (SUM_W+8)'(b2_chan_reg[c]);
            if (scaled[c][SUM_W+7:FRACTION_BITS] > (SUM_W+8-FRACTION_BITS)'(BYTE_MAX)) begin
                byte_next[c] = BYTE_MAX;
            end else begin
                byte_next[c] = scaled[c][FRACTION_BITS +: 8];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= b2_valid_reg;
        end
        if (out_ready) begin
            m_red   <= b2_gray_reg ? b2_lit_reg : byte_next[CH_RED];
            m_green <= b2_gray_reg ? b2_lit_reg : byte_next[CH_GREEN];
            m_blue  <= b2_gray_reg ? b2_lit_reg : byte_next[CH_BLUE];
        end
    end

endmodule

`default_nettype wire

[hdl/hsl_to_rgb_converter_top.sv]
// Top level of the HSL to RGB converter: front end, queue, back end and input credit.
//
// Usage: one pixel per transfer on the s_ channel (hue in degrees 0..359, values up to
// 511 wrap modulo 360; saturation and lightness as fractions of 255). One result per
// pixel leaves on the m_ channel as red, green and blue bytes, in input order.
// Both channels use valid/ready; a transfer happens when both are high.
// Path: an input transfer reaches m_valid, when nothing is stalled, through four
// front-end stages, the queue write, two back-end stages and the output register.
// Throughput: one pixel per clock, sustained, as long as m_ready stays high.
// The front end never stalls. An occupancy counter admits a pixel only while fewer than
// QUEUE_DEPTH (8) pixels sit in the front end and the queue together, so s_ready drops
// once a held back end lets them fill up, and rises again as it drains.
// When the receiver stalls, the output register holds its result and the back-end
// stages fill behind it; the next result follows in the cycle after m_ready returns.
// Reset (aresetn low, synchronous) empties all stages and the queue; m_valid is low and
// s_ready high in the first cycle after reset.
`default_nettype none

module hsl_to_rgb_converter_top
    import h2r_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [8:0]  s_hue_degrees,
    input  wire logic [7:0]  s_saturation,
    input  wire logic [7:0]  s_lightness,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_red,
    output logic [7:0]       m_green,
    output logic [7:0]       m_blue
);

    logic                in_xfer;
    logic                job_valid;
    h2r_job_t            job;
    logic                q_valid;
    logic                q_ready;
    h2r_job_t            q_job;
    logic [QCOUNT_W-1:0] occ_reg;
    logic [QCOUNT_W-1:0] occ_next;
    logic                pop;

    // Credit for pixels in the front end plus the queue.
    assign in_xfer  = s_valid && s_ready;
    assign pop      = q_valid && q_ready;
    assign s_ready  = (occ_reg < QCOUNT_W'(QUEUE_DEPTH));
    assign occ_next = occ_reg + QCOUNT_W'(in_xfer) - QCOUNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    h2r_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (in_xfer),
        .in_hue_degrees (s_hue_degrees),
        .in_saturation  (s_saturation),
        .in_lightness   (s_lightness),
        .job_valid      (job_valid),
        .job            (job)
    );

    h2r_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (job_valid),
        .wr_job   (job),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_job   (q_job)
    );

    h2r_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .job       (q_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_red     (m_red),
        .m_green   (m_green),
        .m_blue    (m_blue)
    );

endmodule

`default_nettype wire

[hdl/h2r_checker.sv]
// Port-level checks for the HSL to RGB converter and the bind that attaches them.
`default_nettype none

module h2r_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic [8:0] s_hue_degrees,
    input wire logic [7:0] s_saturation,
    input wire logic [7:0] s_lightness,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_red,
    input wire logic [7:0] m_green,
    input wire logic [7:0] m_blue
);

    // A stalled result stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its channel bytes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_red) && $stable(m_green) && $stable(m_blue))
        else $error("result bytes changed while stalled");

    // A stalled input pixel stays offered with the same fields.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_hue_degrees)
            && $stable(s_saturation) && $stable(s_lightness))
        else $error("input pixel changed while stalled");

    // Reset leaves no result pending and the input open.
    assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid && s_ready)
        else $error("block not empty after reset");

    // The input closes only after an input transfer filled the last credit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(s_valid))
        else $error("input closed without a transfer");

endmodule

bind hsl_to_rgb_converter_top h2r_checker u_h2r_checker (.*);

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for the HSL to RGB converter with an independent pixel predictor.
`timescale 1ns / 100ps

module tb;
    import h2r_pkg::*;

    // Cycles with no transfer on either channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 4000;
    // Cycles to wait after the last expected result; the pipeline is eight stages deep.
    localparam int DRAIN_CYCLES = 24;
    // Length of the long receiver hold-off that fills the converter.
    localparam int LONG_HOLD_CYCLES = 60;

    localparam logic [63:0] UNIT = 64'd1 << FRACTION_BITS;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [8:0] s_hue_degrees;
    logic [7:0] s_saturation;
    logic [7:0] s_lightness;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_red;
    logic [7:0] m_green;
    logic [7:0] m_blue;

    // Colors predicted for pixels that were accepted but whose results have not yet come back.
    rgb_t pending_rgb[$];

    int  mismatch_count = 0;
    int  pixels_sent = 0;
    int  gray_pixels = 0;
    int  wrapped_hues = 0;
    int  colors_checked = 0;
    int  input_stall_cycles = 0;
    bit  sender_gaps_on = 1'b1;
    bit  receiver_gaps_on = 1'b1;
    int  hold_request = 0;

    hsl_to_rgb_converter_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_hue_degrees (s_hue_degrees),
        .s_saturation  (s_saturation),
        .s_lightness   (s_lightness),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue)
    );

    // Clock with a 2 ns period.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Piecewise hue-to-channel rule, evaluated at one wrapped hue position.
    function automatic logic [63:0] channel_level(input logic [63:0] lo, input logic [63:0] hi,
                                                  input logic [63:0] pos);
        logic [63:0] span;
        logic [63:0] two_thirds;
        span = hi - lo;
        two_thirds = (2 * UNIT) / 3;
        if (6 * pos < UNIT) begin
            return lo + ((span * 6 * pos) >> FRACTION_BITS);
        end else if (2 * pos < UNIT) begin
            return hi;
        end else if (3 * pos < 2 * UNIT) begin
            return lo + ((span * (two_thirds - pos) * 6) >> FRACTION_BITS);
        end
        return lo;
    endfunction

    // Converts a fixed-point level to a byte, truncating and saturating at full scale.
    function automatic logic [7:0] level_to_byte(input logic [63:0] level);
        logic [63:0] scaled;
        scaled = (level * 255) >> FRACTION_BITS;
        return (scaled > 255) ? 8'd255 : scaled[7:0];
    endfunction

    // Predicts the color of one pixel.
    function automatic rgb_t predict_rgb(input logic [8:0] hue, input logic [7:0] sat,
                                         input logic [7:0] lit);
        logic [63:0] hue_deg;
        logic [63:0] sat_fx;
        logic [63:0] lit_fx;
        logic [63:0] hue_fx;
        logic [63:0] third;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] pos_red;
        logic [63:0] pos_blue;
        rgb_t        color;
        hue_deg = 64'(hue);
        if (hue_deg >= 360) begin
            hue_deg = hue_deg - 360;
        end
        // A gray pixel passes the lightness byte straight through.
        if (sat == 8'd0) begin
            color.red = lit;
            color.green = lit;
            color.blue = lit;
            return color;
        end
        sat_fx = (64'(sat) * UNIT) / 255;
        lit_fx = (64'(lit) * UNIT) / 255;
        hue_fx = (hue_deg * UNIT) / 360;
        third = UNIT / 3;
        if (2 * lit_fx < UNIT) begin
            hi = (lit_fx * (UNIT + sat_fx)) >> FRACTION_BITS;
        end else begin
            hi = lit_fx + sat_fx - ((lit_fx * sat_fx) >> FRACTION_BITS);
        end
        lo = (2 * lit_fx < hi) ? 64'd0 : 2 * lit_fx - hi;
        if (hi < lo) begin
            hi = lo;
        end
        // Red sits a third ahead of the hue and blue a third behind, both wrapped.
        pos_red = hue_fx + third;
        if (pos_red >= UNIT) begin
            pos_red = pos_red - UNIT;
        end
        pos_blue = (hue_fx >= third) ? hue_fx - third : hue_fx + UNIT - third;
        color.red = level_to_byte(channel_level(lo, hi, pos_red));
        color.green = level_to_byte(channel_level(lo, hi, hue_fx));
        color.blue = level_to_byte(channel_level(lo, hi, pos_blue));
        return color;
    endfunction

    // Offers one pixel, optionally after an idle burst, and records its predicted color.
    task automatic send_pixel(input logic [8:0] hue, input logic [7:0] sat,
                              input logic [7:0] lit);
        if (sender_gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_hue_degrees <= hue;
        s_saturation <= sat;
        s_lightness <= lit;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        pending_rgb.push_back(predict_rgb(hue, sat, lit));
        pixels_sent++;
        if (sat == 8'd0) begin
            gray_pixels++;
        end
        if (hue >= 9'd360) begin
            wrapped_hues++;
        end
    endtask

    // Sends a pixel with random content; some hues lie in the wrap range, some pixels are gray.
    task automatic send_random_pixel();
        logic [8:0] hue;
        logic [7:0] sat;
        hue = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(360, 511))
                                          : 9'($urandom_range(0, 359));
        sat = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
        send_pixel(hue, sat, 8'($urandom_range(0, 255)));
    endtask

    // Drops valid and waits until every outstanding result has come back.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_rgb.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Extremes of every field, gray pixels, hue wrap and the sector boundaries.
    task automatic test_directed();
        send_pixel(9'd0, 8'd0, 8'd0);
        send_pixel(9'd0, 8'd0, 8'd255);
        send_pixel(9'd200, 8'd0, 8'd128);
        send_pixel(9'd0, 8'd255, 8'd0);
        send_pixel(9'd0, 8'd255, 8'd255);
        send_pixel(9'd0, 8'd255, 8'd127);
        send_pixel(9'd0, 8'd255, 8'd128);
        send_pixel(9'd59, 8'd255, 8'd127);
        send_pixel(9'd60, 8'd255, 8'd128);
        send_pixel(9'd119, 8'd200, 8'd100);
        send_pixel(9'd120, 8'd200, 8'd100);
        send_pixel(9'd180, 8'd128, 8'd200);
        send_pixel(9'd239, 8'd1, 8'd1);
        send_pixel(9'd240, 8'd170, 8'd85);
        send_pixel(9'd300, 8'd255, 8'd254);
        send_pixel(9'd359, 8'd255, 8'd128);
        send_pixel(9'd359, 8'd1, 8'd254);
        send_pixel(9'd360, 8'd255, 8'd128);
        send_pixel(9'd480, 8'd255, 8'd128);
        send_pixel(9'd511, 8'd255, 8'd255);
        send_pixel(9'd511, 8'd0, 8'd77);
        send_pixel(9'd256, 8'd128, 8'd64);
        wait_for_drain();
    endtask

    // Random pixels with idle bursts on both sides.
    task automatic test_random_mix();
        repeat (150) send_random_pixel();
    endtask

    // The receiver holds off for a long stretch while pixels keep coming, so s_ready drops.
    task automatic test_backpressure();
        sender_gaps_on = 1'b0;
        hold_request = LONG_HOLD_CYCLES;
        repeat (30) send_random_pixel();
        sender_gaps_on = 1'b1;
        wait_for_drain();
    endtask

    // The sender pauses halfway until the converter has fully drained.
    task automatic test_pause_and_resume();
        repeat (40) send_random_pixel();
        wait_for_drain();
        repeat (40) send_random_pixel();
    endtask

    // Back-to-back transfers with no idling on either side.
    task automatic test_full_rate();
        sender_gaps_on = 1'b0;
        receiver_gaps_on = 1'b0;
        repeat (120) send_random_pixel();
        s_valid <= 1'b0;
    endtask

    // Receiver: idle bursts, the occasional long hold-off, otherwise always ready.
    initial begin : receiver
        int hold;
        forever begin
            if (hold_request > 0) begin
                hold = hold_request;
                hold_request = 0;
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end else if (receiver_gaps_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Reports one channel that differs from its prediction.
    task automatic report_channel(input string channel, input logic [7:0] want,
                                  input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s channel mismatch: expected %0d, actual %0d",
                     $time, channel, want, got);
            mismatch_count++;
        end
    endtask

    // Compares each result transfer with the oldest predicted color.
    always @(posedge aclk) begin : check_results
        rgb_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rgb.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %0d/%0d/%0d",
                         $time, m_red, m_green, m_blue);
                mismatch_count++;
            end else begin
                want = pending_rgb.pop_front();
                report_channel("red", want.red, m_red);
                report_channel("green", want.green, m_green);
                report_channel("blue", want.blue, m_blue);
                colors_checked++;
            end
        end
        if (aresetn && s_valid && !s_ready) begin
            input_stall_cycles++;
        end
    end

    // Watchdog: ends the run once no transfer has happened for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: timeout after %0d idle cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, pending_rgb.size());
        $display("Mismatches found");
        $finish;
    end

    // Test sequence.
    initial begin : main
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_hue_degrees <= 9'd0;
        s_saturation <= 8'd0;
        s_lightness <= 8'd0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_mix();
        test_backpressure();
        test_pause_and_resume();
        test_full_rate();

        // Let the pipeline empty, then allow time for any stray result.
        @(posedge aclk);
        while (pending_rgb.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_rgb.size() != 0) begin
            $display("%0t: %0d predicted colors never arrived", $time, pending_rgb.size());
            mismatch_count++;
        end

        $display("Converted %0d pixels (%0d gray, %0d with wrapped hue), checked %0d colors.",
                 pixels_sent, gray_pixels, wrapped_hues, colors_checked);
        $display("Input was held off for %0d cycles under receiver back-pressure.",
                 input_stall_cycles);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[files.f]
hdl/h2r_pkg.sv
hdl/h2r_front.sv
hdl/h2r_queue.sv
hdl/h2r_back.sv
hdl/hsl_to_rgb_converter_top.sv
hdl/h2r_checker.sv
dv/tb.sv
